@@ rtl/kps_pkg.sv @@
// Package for the matrix keypad scanner: scan phase type, register indexes,
// result struct and the row priority function. It has no dependencies.
`timescale 1ns / 1ps

package kps_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_SETTLE  = 2'd2,
        PH_SCAN    = 2'd3
    } t_phase;

    localparam logic [1:0] CFG_SETTLE_TICKS = 2'd0;
    localparam logic [1:0] CFG_COLUMN_TICKS = 2'd1;

    localparam logic [9:0] SETTLE_TICKS_RESET = 10'd100;
    localparam logic [7:0] COLUMN_TICKS_RESET = 8'd10;
    localparam logic [1:0] FIRST_COLUMN       = 2'd3;
    localparam logic [3:0] ALL_COLUMNS        = 4'hF;

    typedef struct packed {
        logic [3:0] column_drive;
        logic       key_valid;
        logic [1:0] key_row;
        logic [1:0] key_column;
    } t_result;

    function automatic logic [1:0] lowest_row(input logic [3:0] rows);
        logic [1:0] idx;
        if (rows[0]) begin
            idx = 2'd0;
        end else if (rows[1]) begin
            idx = 2'd1;
        end else if (rows[2]) begin
            idx = 2'd2;
        end else begin
            idx = 2'd3;
        end
        return idx;
    endfunction

endpackage

@@ rtl/kps_core.sv @@
// Scan state machine with the configuration registers and the dwell counter.
// Depends on kps_pkg for the phase type, register indexes and result struct.
`timescale 1ns / 1ps

module kps_core
    import kps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_write,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    input  logic       i_advance,
    input  logic [3:0] i_rows,
    output t_result    o_result
);

    t_phase     r_phase, n_phase;
    logic [1:0] r_column, n_column;
    logic [9:0] r_wait, n_wait;
    logic [9:0] r_settle_ticks;
    logic [7:0] r_column_ticks;
    logic [10:0] w_wait_inc;
    logic        w_any_row;
    t_result     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_TICKS_RESET;
            r_column_ticks <= COLUMN_TICKS_RESET;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data;
                CFG_COLUMN_TICKS: r_column_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_column <= FIRST_COLUMN;
            r_wait   <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_column <= n_column;
            r_wait   <= n_wait;
        end
    end

    always_comb begin
        w_wait_inc = {1'b0, r_wait} + 11'd1;
        w_any_row  = (i_rows != 4'd0);
        n_phase    = r_phase;
        n_column   = r_column;
        n_wait     = r_wait;
        w_res      = '{column_drive: ALL_COLUMNS, key_valid: 1'b0,
                       key_row: 2'd0, key_column: 2'd0};
        unique case (r_phase)
            PH_IDLE: begin
                if (w_any_row) begin
                    n_phase = PH_CONFIRM;
                end
            end
            PH_CONFIRM: begin
                if (w_any_row) begin
                    n_phase = PH_SETTLE;
                    n_wait  = '0;
                end
            end
            PH_SETTLE: begin
                if (w_wait_inc >= {1'b0, r_settle_ticks}) begin
                    n_wait = '0;
                    if (w_any_row) begin
                        n_phase  = PH_SCAN;
                        n_column = FIRST_COLUMN;
                    end else begin
                        n_phase = PH_CONFIRM;
                    end
                end else begin
                    n_wait = w_wait_inc[9:0];
                end
            end
            PH_SCAN: begin
                w_res.column_drive = 4'd1 << r_column;
                if (w_wait_inc >= {3'd0, r_column_ticks}) begin
                    n_wait = '0;
                    if (w_any_row) begin
                        w_res.key_valid  = 1'b1;
                        w_res.key_row    = lowest_row(i_rows);
                        w_res.key_column = r_column;
                        n_phase          = PH_IDLE;
                        n_column         = FIRST_COLUMN;
                    end else if (r_column == 2'd0) begin
                        n_phase  = PH_IDLE;
                        n_column = FIRST_COLUMN;
                    end else begin
                        n_column = r_column - 2'd1;
                    end
                end else begin
                    n_wait = w_wait_inc[9:0];
                end
            end
            default: ;
        endcase
    end

    assign o_result = w_res;

    a_drive_all_outside_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SCAN) |-> (w_res.column_drive == ALL_COLUMNS && !w_res.key_valid))
        else $error("columns not all driven or key reported outside the scan");

    a_drive_onehot_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SCAN) |-> $onehot(w_res.column_drive))
        else $error("scan does not drive exactly one column");

    a_idle_after_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_res.key_valid) |=> (r_phase == PH_IDLE && r_column == FIRST_COLUMN))
        else $error("scanner did not return to idle after a key event");

    a_hold_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_phase) && $stable(r_wait) && $stable(r_column)))
        else $error("scan state changed without a tick");

endmodule

@@ rtl/kps_out_reg.sv @@
// Output register for the result items, with valid and ready towards the sink.
// Depends on kps_pkg for the result struct.
`timescale 1ns / 1ps

module kps_out_reg
    import kps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !i_load)
        else $error("pending result overwritten");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_result)))
        else $error("stalled result changed");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not presented");

endmodule

@@ rtl/matrix_keypad_scanner_debounce_top.sv @@
// Top level of the 4x4 matrix keypad scanner with debounce.
// Depends on kps_pkg, kps_core and kps_out_reg.
//
// Channel   Direction  Handshake                  Payload
// tick in   sink       i_in_valid / o_in_ready    i_row_lines
// result    source     o_out_valid / i_out_ready  o_column_drive, o_key_valid,
//                                                 o_key_row, o_key_column
// config    sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One tick is taken per cycle while o_in_ready is high; a tick passes from the input
// register through the scan state machine into the result register, which then
// presents the result to the sink until it transfers out.
// Reset is synchronous and active low; it restores the register defaults and idle.
// A stalled result holds in the result register while one more tick waits in
// the input register; further ticks are refused until the sink takes a result.
// Configuration writes are always taken.
`timescale 1ns / 1ps

module matrix_keypad_scanner_debounce_top
    import kps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [3:0] i_row_lines,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_column_drive,
    output logic       o_key_valid,
    output logic [1:0] o_key_row,
    output logic [1:0] o_key_column,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);

    logic       r_in_valid;
    logic [3:0] r_rows;
    logic       w_space;
    logic       w_advance;
    t_result    w_core_result;
    t_result    w_out_result;

    assign w_advance   = r_in_valid && w_space;
    assign o_in_ready  = !r_in_valid || w_space;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_rows <= i_row_lines;
        end
    end

    kps_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (w_advance),
        .i_rows      (r_rows),
        .o_result    (w_core_result)
    );

    kps_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_core_result),
        .o_space  (w_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_out_result)
    );

    assign o_column_drive = w_out_result.column_drive;
    assign o_key_valid    = w_out_result.key_valid;
    assign o_key_row      = w_out_result.key_row;
    assign o_key_column   = w_out_result.key_column;

endmodule
